### rtl/core/cdmd_pkg.sv
// ----------------------------------------------------------------------------
// Colour difference mask and dilation: shared definitions
// Geometry limits, register indexes, item types and queue depths.
// ----------------------------------------------------------------------------
package cdmd_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int FW_BITS       = 12;
    localparam int FH_BITS       = 13;
    localparam int THR_BITS      = 8;
    localparam int PIX_BITS      = 8;
    localparam int CFG_DATA_BITS = 13;

    localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int EXT_BITS   = (FW_BITS > W_BITS) ? FW_BITS : W_BITS;
    localparam int RING_AW    = $clog2(MAX_WIDTH) + 2;
    localparam int RING_DEPTH = 1 << RING_AW;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_PW    = $clog2(JQ_DEPTH);
    localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic                FUNC_PIXEL = 1'b0;
    localparam logic [PIX_BITS-1:0] MASK_SET   = PIX_BITS'(255);
    localparam logic [PIX_BITS-1:0] MASK_CLEAR = '0;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_DIFF_THRESHOLD = 2'd2,
        CFG_TARGET_RED     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                func;
        logic [PIX_BITS-1:0] blue;
        logic [PIX_BITS-1:0] red;
    } sample_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] mask_value;
        logic                last_in_frame;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic               data;
    } ring_wr_t;

    typedef struct packed {
        logic [RING_AW-1:0] up_addr;
        logic [RING_AW-1:0] center_addr;
        logic [RING_AW-1:0] down_addr;
        logic               up_ok;
        logic               left_ok;
        logic               right_ok;
        logic               down_ok;
        logic               last;
    } job_t;

endpackage

### rtl/core/color_diff_mask_dilate_unit.sv
// ----------------------------------------------------------------------------
// Colour difference mask and dilation unit
// Thresholds red/blue channel difference per pixel and dilates the mask with
// a plus-shaped 3x3 cross, streaming in raster order.
//
//   channel   handshake              payload
//   input     push / full            sample   (func, blue, red)
//   output    empty / pop            result   (mask_value, last_in_frame)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle on both sides while full is low and a result is waiting;
// cfg_ready is always high. A result passes the job queue register, then the
// registered read of the line ring, then the result queue.
// Asynchronous reset clears control state only; the line ring is not cleared.
// full rises when the four-entry job queue fills; the back end stops reading
// jobs when the four-entry result queue has no room.
// ----------------------------------------------------------------------------
module color_diff_mask_dilate_unit
    import cdmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  sample_t                  sample,
    output logic                     empty,
    input  logic                     pop,
    output result_t                  result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic     accept;
    logic     job_push;
    logic     job_full;
    logic     job_empty;
    logic     job_pop;
    job_t     job_new;
    job_t     job_head;
    ring_wr_t ring_wr;

    assign cfg_ready = 1'b1;
    assign full      = job_full;

    cdmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .sample    (sample),
        .job_full  (job_full),
        .accept    (accept),
        .job_push  (job_push),
        .job       (job_new),
        .ring_wr   (ring_wr)
    );

    cdmd_job_fifo u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_new),
        .full    (job_full),
        .pop     (job_pop),
        .job_out (job_head),
        .empty   (job_empty)
    );

    cdmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_wr   (ring_wr),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    a_accept_gate: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !job_full)
        else $error("item taken while the job queue is full");

endmodule

### rtl/core/cdmd_front.sv
// ----------------------------------------------------------------------------
// Colour difference mask and dilation: front end
// Holds configuration, thresholds each pixel into a mask bit, writes it to
// the line ring and issues one output job per released pixel.
// ----------------------------------------------------------------------------
module cdmd_front
    import cdmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     push,
    input  sample_t                  sample,
    input  logic                     job_full,
    output logic                     accept,
    output logic                     job_push,
    output job_t                     job,
    output ring_wr_t                 ring_wr
);

    logic [FW_BITS-1:0]  frame_width_reg;
    logic [FH_BITS-1:0]  frame_height_reg;
    logic [THR_BITS-1:0] diff_threshold_reg;
    logic                target_red_reg;

    logic [W_BITS-1:0]  pending_reg, pending_next;
    logic [RING_AW-1:0] wptr_reg, wptr_next;
    logic [W_BITS-1:0]  out_col_reg, out_col_next;
    logic [FH_BITS-1:0] out_row_reg, out_row_next;

    logic [EXT_BITS-1:0]        fw_ext;
    logic [W_BITS-1:0]          w_eff, w_last;
    logic [FH_BITS-1:0]         h_eff, h_last;
    logic signed [PIX_BITS:0]   diff;
    logic                       new_bit;
    logic                       is_pixel;
    logic [W_BITS:0]            avail;
    logic                       emit;
    logic [RING_AW-1:0]         center;
    logic                       restart;

    always_comb
    begin
        fw_ext = EXT_BITS'(frame_width_reg);
        priority if (fw_ext == '0)
        begin
            w_eff = W_BITS'(1);
        end
        else if (fw_ext > EXT_BITS'(MAX_WIDTH))
        begin
            w_eff = W_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_BITS'(fw_ext);
        end
    end

    assign h_eff  = (frame_height_reg == '0) ? FH_BITS'(1) : frame_height_reg;
    assign w_last = w_eff - W_BITS'(1);
    assign h_last = h_eff - FH_BITS'(1);

    always_comb
    begin
        if (target_red_reg)
        begin
            diff = $signed({1'b0, sample.red}) - $signed({1'b0, sample.blue});
        end
        else
        begin
            diff = $signed({1'b0, sample.blue}) - $signed({1'b0, sample.red});
        end
    end

    assign new_bit  = diff > $signed({1'b0, diff_threshold_reg});
    assign is_pixel = sample.func == FUNC_PIXEL;
    assign avail    = is_pixel ? ((W_BITS + 1)'(pending_reg) + (W_BITS + 1)'(1))
                               : (W_BITS + 1)'(pending_reg);
    assign emit     = is_pixel ? (pending_reg >= w_eff) : (pending_reg != '0);
    assign center   = wptr_reg - RING_AW'(pending_reg);

    assign accept   = push && !job_full;
    assign job_push = accept && emit;

    always_comb
    begin
        job.center_addr = center;
        job.up_addr     = center - RING_AW'(w_eff);
        job.down_addr   = center + RING_AW'(w_eff);
        job.up_ok       = out_row_reg != '0;
        job.left_ok     = out_col_reg != '0;
        job.right_ok    = (out_col_reg < w_last) && (avail > (W_BITS + 1)'(1));
        job.down_ok     = (out_row_reg < h_last) && (avail > {1'b0, w_eff});
        job.last        = (out_row_reg == h_last) && (out_col_reg == w_last);
    end

    always_comb
    begin
        ring_wr.en   = accept && is_pixel;
        ring_wr.addr = wptr_reg;
        ring_wr.data = new_bit;
    end

    assign restart = cfg_valid
                     && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    always_comb
    begin
        pending_next = pending_reg;
        wptr_next    = wptr_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (restart)
        begin
            pending_next = '0;
            wptr_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            pending_next = W_BITS'(avail - (W_BITS + 1)'(emit));
            if (is_pixel)
            begin
                wptr_next = wptr_reg + RING_AW'(1);
            end
            if (emit)
            begin
                if (out_col_reg == w_last)
                begin
                    out_col_next = '0;
                    out_row_next = (out_row_reg == h_last) ? '0
                                                           : out_row_reg + FH_BITS'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + W_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            wptr_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            wptr_reg    <= wptr_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FW_BITS'(640);
            frame_height_reg   <= FH_BITS'(480);
            diff_threshold_reg <= THR_BITS'(100);
            target_red_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[FW_BITS-1:0];
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[FH_BITS-1:0];
                CFG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_data[THR_BITS-1:0];
                CFG_TARGET_RED:     target_red_reg     <= cfg_data[0];
                default:            target_red_reg     <= target_red_reg;
            endcase
        end
    end

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= w_eff)
        else $error("pending count exceeds row width");

    a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_col_reg < w_eff)
        else $error("output column outside row");

endmodule

### rtl/core/cdmd_job_fifo.sv
// ----------------------------------------------------------------------------
// Colour difference mask and dilation: job queue
// Short queue of output jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module cdmd_job_fifo
    import cdmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    output logic full,
    input  logic pop,
    output job_t job_out,
    output logic empty
);

    job_t             mem_q [JQ_DEPTH];
    logic [JQ_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JQ_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JQ_CW-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == JQ_CW'(JQ_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = mem_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + JQ_PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + JQ_PW'(1) : rd_ptr_reg;
        count_next  = count_reg + JQ_CW'(do_push) - JQ_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_q[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_jq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> count_reg == $past(count_reg) + JQ_CW'(1))
        else $error("job queue count lost a push");

endmodule

### rtl/core/cdmd_back.sv
// ----------------------------------------------------------------------------
// Colour difference mask and dilation: back end
// Keeps the mask line ring, reads the cross neighbourhood of each job,
// forms the dilated pixel and queues it for the consumer.
// ----------------------------------------------------------------------------
module cdmd_back
    import cdmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ring_wr_t ring_wr,
    input  logic     job_empty,
    input  job_t     job,
    output logic     job_pop,
    input  logic     pop,
    output logic     empty,
    output result_t  result
);

    logic mem_a [RING_DEPTH];
    logic mem_b [RING_DEPTH];

    logic               up_bit_reg, down_bit_reg, ctr_bit_reg, right_bit_reg;
    logic               left_bit_reg;
    job_t               s1_job_reg;
    logic               s1_valid_reg;
    logic [RING_AW-1:0] right_addr;
    logic [RQ_CW:0]     credit;
    logic               issue;
    logic               dilated;
    result_t            res_in;

    result_t          rq_mem [RQ_DEPTH];
    logic [RQ_PW-1:0] rq_wr_ptr_reg, rq_rd_ptr_reg;
    logic [RQ_CW-1:0] rq_count_reg, rq_count_next;
    logic             rq_pop;

    assign credit     = (RQ_CW + 1)'(rq_count_reg) + (RQ_CW + 1)'(s1_valid_reg);
    assign issue      = !job_empty && (credit < (RQ_CW + 1)'(RQ_DEPTH));
    assign job_pop    = issue;
    assign right_addr = job.center_addr + RING_AW'(1);

    always_ff @(posedge clk)
    begin
        if (ring_wr.en)
        begin
            mem_a[ring_wr.addr] <= ring_wr.data;
            mem_b[ring_wr.addr] <= ring_wr.data;
        end
        if (issue)
        begin
            up_bit_reg    <= mem_a[job.up_addr];
            down_bit_reg  <= mem_a[job.down_addr];
            ctr_bit_reg   <= mem_b[job.center_addr];
            right_bit_reg <= mem_b[right_addr];
            s1_job_reg    <= job;
        end
        if (s1_valid_reg)
        begin
            left_bit_reg <= ctr_bit_reg;
        end
    end

    always_comb
    begin
        dilated = ctr_bit_reg
                  | (s1_job_reg.up_ok    & up_bit_reg)
                  | (s1_job_reg.left_ok  & left_bit_reg)
                  | (s1_job_reg.right_ok & right_bit_reg)
                  | (s1_job_reg.down_ok  & down_bit_reg);
        res_in.mask_value    = dilated ? MASK_SET : MASK_CLEAR;
        res_in.last_in_frame = s1_job_reg.last;
    end

    assign empty         = rq_count_reg == '0;
    assign rq_pop        = pop && !empty;
    assign result        = rq_mem[rq_rd_ptr_reg];
    assign rq_count_next = rq_count_reg + RQ_CW'(s1_valid_reg) - RQ_CW'(rq_pop);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            rq_mem[rq_wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_count_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            rq_wr_ptr_reg <= s1_valid_reg ? rq_wr_ptr_reg + RQ_PW'(1) : rq_wr_ptr_reg;
            rq_rd_ptr_reg <= rq_pop ? rq_rd_ptr_reg + RQ_PW'(1) : rq_rd_ptr_reg;
            rq_count_reg  <= rq_count_next;
        end
    end

    a_rq_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> rq_count_reg < RQ_CW'(RQ_DEPTH))
        else $error("result queue overflow");

    a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_valid_reg)
        else $error("issued job did not reach the read stage");

endmodule
